// ===== rtl/apfb_pkg.sv =====
// ----------------------------------------------------------------------------
// apfb_pkg
// Shared types and constants for the ARP and neighbor solicitation frame
// builder.
// ----------------------------------------------------------------------------
package apfb_pkg;

   localparam int unsigned MacWidth     = 48;
   localparam int unsigned AddrWidth    = 64;
   localparam int unsigned WordWidth    = 64;
   localparam int unsigned IdxWidth     = 4;
   localparam int unsigned BytesWidth   = 4;
   localparam int unsigned IndexWidth   = 2;
   localparam int unsigned SumWidth     = 22;

   localparam logic [IndexWidth-1:0] REG_SOURCE_MAC     = 2'd0;
   localparam logic [IndexWidth-1:0] REG_SOURCE_IP_HIGH = 2'd1;
   localparam logic [IndexWidth-1:0] REG_SOURCE_IP_LOW  = 2'd2;

   localparam logic METHOD_ARP = 1'b0;
   localparam logic METHOD_NS  = 1'b1;

   localparam logic [IdxWidth-1:0] ARP_LAST_WORD = 4'd5;
   localparam logic [IdxWidth-1:0] NS_LAST_WORD  = 4'd10;
   localparam logic [IdxWidth-1:0] NS_CSUM_WORD  = 4'd7;

   localparam logic [BytesWidth-1:0] FULL_BYTES     = 4'd8;
   localparam logic [BytesWidth-1:0] ARP_LAST_BYTES = 4'd2;
   localparam logic [BytesWidth-1:0] NS_LAST_BYTES  = 4'd6;

   // Fixed 16-bit terms of the ICMPv6 checksum: ff02, 0001 of the
   // destination, payload length, next header, type/code, and option header.
   localparam logic [SumWidth-1:0] CSUM_FIXED = 22'h01875E;

   typedef struct packed {
      logic [MacWidth-1:0]  mac;
      logic [AddrWidth-1:0] ip_high;
      logic [AddrWidth-1:0] ip_low;
   } cfg_type;

   typedef struct packed {
      logic                issue;
      logic [IdxWidth-1:0] word_idx;
   } csum_ctl_type;

endpackage

// ===== rtl/apfb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// apfb_cfg_regs
// Holds the source MAC and source address registers written over the
// configuration channel.
// ----------------------------------------------------------------------------
module apfb_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apfb_pkg::IndexWidth-1:0]     csr_index,
   input  logic [apfb_pkg::AddrWidth-1:0]      csr_data,
   output apfb_pkg::cfg_type                   cfg
);

   apfb_pkg::cfg_type cfg_ff;
   apfb_pkg::cfg_type cfg_in;
   logic              write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            apfb_pkg::REG_SOURCE_MAC: begin
               cfg_in.mac = csr_data[apfb_pkg::MacWidth-1:0];
            end
            apfb_pkg::REG_SOURCE_IP_HIGH: begin
               cfg_in.ip_high = csr_data;
            end
            apfb_pkg::REG_SOURCE_IP_LOW: begin
               cfg_in.ip_low = csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/apfb_csum_acc.sv =====
// ----------------------------------------------------------------------------
// apfb_csum_acc
// Accumulates the ICMPv6 checksum over the first five words of a frame and
// folds it to the final 16-bit value.
// ----------------------------------------------------------------------------
module apfb_csum_acc (
   input  logic                                clock,
   input  apfb_pkg::csum_ctl_type              ctl,
   input  logic [apfb_pkg::AddrWidth-1:0]      target_ip_high,
   input  logic [apfb_pkg::AddrWidth-1:0]      target_ip_low,
   input  apfb_pkg::cfg_type                   cfg,
   output logic [15:0]                         csum
);

   logic [apfb_pkg::SumWidth-1:0] sum_ff;
   logic [apfb_pkg::SumWidth-1:0] sum_in;
   logic [apfb_pkg::SumWidth-1:0] chunk;
   logic [apfb_pkg::SumWidth-1:0] base;
   logic [16:0]                   fold1;
   logic [15:0]                   fold2;

   function automatic logic [apfb_pkg::SumWidth-1:0] sum4(
      input logic [apfb_pkg::AddrWidth-1:0] v);
      sum4 = apfb_pkg::SumWidth'(v[63:48]) + apfb_pkg::SumWidth'(v[47:32])
           + apfb_pkg::SumWidth'(v[31:16]) + apfb_pkg::SumWidth'(v[15:0]);
   endfunction

   always_comb begin
      case (ctl.word_idx)
         4'd0: chunk = sum4(cfg.ip_high);
         4'd1: chunk = sum4(cfg.ip_low);
         4'd2: chunk = sum4(target_ip_high);
         4'd3: chunk = sum4(target_ip_low);
         4'd4: begin
            chunk = apfb_pkg::CSUM_FIXED
                  + apfb_pkg::SumWidth'(cfg.mac[47:32])
                  + apfb_pkg::SumWidth'(cfg.mac[31:16])
                  + apfb_pkg::SumWidth'(cfg.mac[15:0])
                  + apfb_pkg::SumWidth'({8'hff, target_ip_low[23:16]})
                  + apfb_pkg::SumWidth'(target_ip_low[15:0]);
         end
         default: chunk = '0;
      endcase
   end

   assign base   = (ctl.word_idx == 4'd0) ? '0 : sum_ff;
   assign sum_in = (ctl.issue && ctl.word_idx <= 4'd4) ? base + chunk : sum_ff;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign fold1 = 17'(sum_ff[apfb_pkg::SumWidth-1:16]) + 17'(sum_ff[15:0]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);
   assign csum  = (fold2 == 16'hffff) ? 16'hffff : ~fold2;

endmodule

// ===== rtl/apfb_word_sel.sv =====
// ----------------------------------------------------------------------------
// apfb_word_sel
// Assembles one 64-bit frame word, its byte count and end flag from the
// held request, the configuration and the checksum.
// ----------------------------------------------------------------------------
module apfb_word_sel (
   input  logic                                method,
   input  logic [apfb_pkg::IdxWidth-1:0]       word_idx,
   input  logic [apfb_pkg::AddrWidth-1:0]      target_ip_high,
   input  logic [apfb_pkg::AddrWidth-1:0]      target_ip_low,
   input  apfb_pkg::cfg_type                   cfg,
   input  logic [15:0]                         csum,
   output logic [apfb_pkg::WordWidth-1:0]      frame_word,
   output logic [apfb_pkg::BytesWidth-1:0]     valid_bytes,
   output logic                                end_of_frame
);

   logic [apfb_pkg::MacWidth-1:0]  mac;
   logic [apfb_pkg::AddrWidth-1:0] sih;
   logic [apfb_pkg::AddrWidth-1:0] sil;
   logic [apfb_pkg::AddrWidth-1:0] th;
   logic [apfb_pkg::AddrWidth-1:0] tl;
   logic [apfb_pkg::WordWidth-1:0] arp_word;
   logic [apfb_pkg::WordWidth-1:0] ns_word;

   assign mac = cfg.mac;
   assign sih = cfg.ip_high;
   assign sil = cfg.ip_low;
   assign th  = target_ip_high;
   assign tl  = target_ip_low;

   always_comb begin
      case (word_idx)
         4'd0:    arp_word = {48'hffff_ffff_ffff, mac[47:32]};
         4'd1:    arp_word = {mac[31:0], 16'h0806, 16'h0001};
         4'd2:    arp_word = {16'h0800, 8'h06, 8'h04, 16'h0001, mac[47:32]};
         4'd3:    arp_word = {mac[31:0], sil[31:0]};
         4'd4:    arp_word = {48'h0, tl[31:16]};
         4'd5:    arp_word = {tl[15:0], 48'h0};
         default: arp_word = '0;
      endcase
   end

   always_comb begin
      case (word_idx)
         4'd0:    ns_word = {16'h3333, 8'hff, tl[23:0], mac[47:32]};
         4'd1:    ns_word = {mac[31:0], 16'h86dd, 16'h6000};
         4'd2:    ns_word = {16'h0000, 16'h0020, 8'h3a, 8'hff, sih[63:48]};
         4'd3:    ns_word = {sih[47:0], sil[63:48]};
         4'd4:    ns_word = {sil[47:0], 16'hff02};
         4'd5:    ns_word = '0;
         4'd6:    ns_word = {16'h0001, 8'hff, tl[23:0], 8'h87, 8'h00};
         4'd7:    ns_word = {csum, 32'h0, th[63:48]};
         4'd8:    ns_word = {th[47:0], tl[63:48]};
         4'd9:    ns_word = {tl[47:0], 8'h01, 8'h01};
         4'd10:   ns_word = {mac, 16'h0};
         default: ns_word = '0;
      endcase
   end

   always_comb begin
      if (method == apfb_pkg::METHOD_NS) begin
         frame_word   = ns_word;
         end_of_frame = (word_idx == apfb_pkg::NS_LAST_WORD);
         valid_bytes  = end_of_frame ? apfb_pkg::NS_LAST_BYTES : apfb_pkg::FULL_BYTES;
      end else begin
         frame_word   = arp_word;
         end_of_frame = (word_idx == apfb_pkg::ARP_LAST_WORD);
         valid_bytes  = end_of_frame ? apfb_pkg::ARP_LAST_BYTES : apfb_pkg::FULL_BYTES;
      end
   end

endmodule

// ===== rtl/arp_ns_probe_frame_builder_core.sv =====
// ----------------------------------------------------------------------------
// arp_ns_probe_frame_builder_core
// Builds one broadcast ARP request or IPv6 neighbor solicitation frame per
// request beat and streams it as 64-bit big-endian words.
// ----------------------------------------------------------------------------
// A request beat is held in an input register and its frame leaves one word
// per cycle through the result register unless a low rsp_ready stalls it: 6
// beats for an ARP request and 11 for a neighbor solicitation. The next
// request is taken in the cycle the last word of the current frame is issued,
// so frames follow each other without gaps. The ICMPv6 checksum is
// accumulated while the first five words go out and is ready for word seven.
// Configuration registers may be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module arp_ns_probe_frame_builder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apfb_pkg::IndexWidth-1:0]     csr_index,
   input  logic [apfb_pkg::AddrWidth-1:0]      csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_method,
   input  logic [apfb_pkg::AddrWidth-1:0]      req_target_ip_high,
   input  logic [apfb_pkg::AddrWidth-1:0]      req_target_ip_low,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [apfb_pkg::WordWidth-1:0]      rsp_frame_word,
   output logic [apfb_pkg::BytesWidth-1:0]     rsp_valid_bytes,
   output logic                                rsp_end_of_frame
);

   apfb_pkg::cfg_type                  cfg;
   apfb_pkg::csum_ctl_type             csum_ctl;
   logic [15:0]                        csum;

   logic                               busy_ff;
   logic                               busy_in;
   logic                               method_ff;
   logic [apfb_pkg::AddrWidth-1:0]     thigh_ff;
   logic [apfb_pkg::AddrWidth-1:0]     tlow_ff;
   logic [apfb_pkg::IdxWidth-1:0]      idx_ff;
   logic [apfb_pkg::IdxWidth-1:0]      idx_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [apfb_pkg::WordWidth-1:0]     word_ff;
   logic [apfb_pkg::BytesWidth-1:0]    bytes_ff;
   logic                               eof_ff;

   logic [apfb_pkg::WordWidth-1:0]     word_next;
   logic [apfb_pkg::BytesWidth-1:0]    bytes_next;
   logic                               eof_next;
   logic                               issue;
   logic                               last_issue;
   logic                               accept;

   apfb_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign issue      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last_issue = issue && eof_next;
   assign req_ready  = !busy_ff || last_issue;
   assign accept     = req_valid && req_ready;

   assign csum_ctl.issue    = issue;
   assign csum_ctl.word_idx = idx_ff;

   apfb_csum_acc u_csum (
      .clock          (clock),
      .ctl            (csum_ctl),
      .target_ip_high (thigh_ff),
      .target_ip_low  (tlow_ff),
      .cfg            (cfg),
      .csum           (csum)
   );

   apfb_word_sel u_word (
      .method         (method_ff),
      .word_idx       (idx_ff),
      .target_ip_high (thigh_ff),
      .target_ip_low  (tlow_ff),
      .cfg            (cfg),
      .csum           (csum),
      .frame_word     (word_next),
      .valid_bytes    (bytes_next),
      .end_of_frame   (eof_next)
   );

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (accept) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (last_issue) begin
         busy_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         method_ff <= req_method;
         thigh_ff  <= req_target_ip_high;
         tlow_ff   <= req_target_ip_low;
      end
      if (issue) begin
         word_ff  <= word_next;
         bytes_ff <= bytes_next;
         eof_ff   <= eof_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_word   = word_ff;
   assign rsp_valid_bytes  = bytes_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule
